>>> src/bpa_pkg.sv
// shared types, constants and helpers of the buddy page allocator
package bpa_pkg;

  // default sizing
  localparam int unsigned DEF_TOP_ORDER  = 10;
  localparam int unsigned DEF_PAGE_SLOTS = 1024;

  // fixed field widths
  localparam int unsigned CMD_W      = 1;
  localparam int unsigned REQ_W      = 11;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned BLK_W      = 10;
  localparam int unsigned FREE_W     = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  // wide scratch width for index and bound arithmetic
  localparam int unsigned WW          = 18;
  // width of a rounded request order and its search limit
  localparam int unsigned RO_W        = 5;
  localparam int unsigned ORDER_LIMIT = 17;
  localparam int unsigned FREE_MAX    = 2047;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK           = 2'd0,
    STAT_NO_BLOCK     = 2'd1,
    STAT_TOO_BIG      = 2'd2,
    STAT_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_PAGES = 1'b0,
    REG_TOTAL_PAGES  = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_TAKE,
    S_SPLIT,
    S_PREAD,
    S_PUNLINK,
    S_PLINK,
    S_PFIX,
    S_FCHECK,
    S_PROBE,
    S_JOIN,
    S_FIN
  } fsm_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_INIT,
    OP_START,
    OP_SCAN,
    OP_TAKE,
    OP_SPLIT,
    OP_PREAD,
    OP_PUNLINK,
    OP_PLINK,
    OP_PFIX,
    OP_FCHECK,
    OP_PROBE,
    OP_JOIN,
    OP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   idle;
  } ctrl_cmd_t;

  typedef struct packed {
    logic region_wr;
    logic clear_last;
    logic start_bad;
    logic start_free;
    logic found;
    logic scan_end;
    logic split_more;
    logic rd_free;
    logic probe_ok;
    logic buddy_match;
    logic mode_alloc;
    logic out_room;
  } dp_flags_t;

  // smallest order whose block holds n pages, zero pages counting as one
  function automatic logic [RO_W-1:0] round_order(input logic [REQ_W-1:0] n);
    logic [RO_W-1:0] o;
    o = '0;
    for (int k = 0; k < ORDER_LIMIT; k++) begin
      if ((WW'(1) << k) < WW'(n)) begin
        o = RO_W'(k + 1);
      end
    end
    return o;
  endfunction

endpackage

>>> src/bpa_ctrl.sv
// sequencing state machine of the buddy page allocator
module bpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  bpa_pkg::dp_flags_t  flags_i,
  output bpa_pkg::ctrl_cmd_t  cmd_o
);
  import bpa_pkg::*;

  fsm_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:   if (flags_i.clear_last) state_d = S_INIT;
      S_INIT:    state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          if (flags_i.start_bad) begin
            state_d = S_FIN;
          end else if (flags_i.start_free) begin
            state_d = S_FCHECK;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (flags_i.found) begin
          state_d = S_TAKE;
        end else if (flags_i.scan_end) begin
          state_d = S_FIN;
        end
      end
      S_TAKE:    state_d = S_SPLIT;
      S_SPLIT:   state_d = flags_i.split_more ? S_PREAD : S_FIN;
      S_PREAD:   state_d = S_PUNLINK;
      S_PUNLINK: state_d = S_PLINK;
      S_PLINK:   state_d = S_PFIX;
      S_PFIX:    state_d = flags_i.mode_alloc ? S_SPLIT : S_FIN;
      S_FCHECK:  state_d = flags_i.rd_free ? S_FIN : S_PROBE;
      S_PROBE:   state_d = flags_i.probe_ok ? S_JOIN : S_PREAD;
      S_JOIN:    state_d = flags_i.buddy_match ? S_PROBE : S_PREAD;
      S_FIN:     if (flags_i.out_room) state_d = S_IDLE;
      default:   state_d = S_CLEAR;
    endcase
    // a region size write restarts the clearing pass
    if (flags_i.region_wr) begin
      state_d = S_CLEAR;
    end
  end

  // datapath command
  always_comb begin
    cmd_o.idle = (state_q == S_IDLE) && !flags_i.region_wr;
    cmd_o.op   = OP_NONE;
    unique case (state_q)
      S_CLEAR:   cmd_o.op = OP_CLEAR;
      S_INIT:    cmd_o.op = OP_INIT;
      S_IDLE:    if (in_valid_i && !flags_i.region_wr) cmd_o.op = OP_START;
      S_SCAN:    cmd_o.op = OP_SCAN;
      S_TAKE:    cmd_o.op = OP_TAKE;
      S_SPLIT:   cmd_o.op = OP_SPLIT;
      S_PREAD:   cmd_o.op = OP_PREAD;
      S_PUNLINK: cmd_o.op = OP_PUNLINK;
      S_PLINK:   cmd_o.op = OP_PLINK;
      S_PFIX:    cmd_o.op = OP_PFIX;
      S_FCHECK:  cmd_o.op = OP_FCHECK;
      S_PROBE:   cmd_o.op = OP_PROBE;
      S_JOIN:    cmd_o.op = OP_JOIN;
      S_FIN:     if (flags_i.out_room) cmd_o.op = OP_FIN;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

>>> src/bpa_datapath.sv
// free list memories, order heads, free page total and result register
module bpa_datapath #(
  parameter int unsigned TOP_ORDER  = bpa_pkg::DEF_TOP_ORDER,
  parameter int unsigned PAGE_SLOTS = bpa_pkg::DEF_PAGE_SLOTS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bpa_pkg::ctrl_cmd_t              cmd_i,
  output bpa_pkg::dp_flags_t              flags_o,
  input  logic [bpa_pkg::CMD_W-1:0]       cmd_field_i,
  input  logic [bpa_pkg::REQ_W-1:0]       request_pages_i,
  input  logic [bpa_pkg::IDX_W-1:0]       page_index_i,
  input  logic                            cfg_valid_i,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bpa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic [bpa_pkg::STAT_W-1:0]      status_o,
  output logic [bpa_pkg::BLK_W-1:0]       block_index_o,
  output logic [bpa_pkg::FREE_W-1:0]      avail_pages_o
);
  import bpa_pkg::*;

  localparam int unsigned IW = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int unsigned LW = IW + 1;
  localparam int unsigned OW = $clog2(TOP_ORDER + 1);
  localparam int unsigned HN = TOP_ORDER + 1;
  localparam int unsigned SW = IW + TOP_ORDER + 1;
  localparam int unsigned FW = OW + 1;
  localparam logic [LW-1:0] NO_LINK = LW'(PAGE_SLOTS);

  // configuration
  logic [CFG_DATA_W-1:0] region_q, total_q;
  logic                  region_wr, total_wr;

  // list state
  logic [LW-1:0] head_q [HN];
  logic [LW-1:0] head_d [HN];
  logic [SW-1:0] sum_q, sum_d;
  logic [IW-1:0] clr_cnt_q;

  // working registers
  logic          mode_alloc_q;
  logic [OW-1:0] o_q, c_q, po_q, fo_q;
  logic [IW-1:0] p_q, pa_q, fa_q, blk_q;
  logic [LW-1:0] h_q;
  status_e       stat_q;

  // result register
  logic                  out_valid_q;
  logic [STAT_W-1:0]     out_stat_q;
  logic [BLK_W-1:0]      out_blk_q;
  logic [FREE_W-1:0]     out_free_q;

  // memories
  logic [FW-1:0] fm_mem [PAGE_SLOTS];
  logic [LW-1:0] nx_mem [PAGE_SLOTS];
  logic [LW-1:0] pv_mem [PAGE_SLOTS];
  logic [FW-1:0] fm_rd_q;
  logic [LW-1:0] nx_rd_q, pv_rd_q;
  logic          fm_we, nx_we, pv_we;
  logic [IW-1:0] fm_wa, nx_wa, pv_wa, fm_ra, ln_ra;
  logic [FW-1:0] fm_wd;
  logic [LW-1:0] nx_wd, pv_wd;

  // derived values
  logic [RO_W-1:0] ro;
  logic            start_bad;
  logic [LW-1:0]   head_c;
  logic            rd_free;
  logic [OW-1:0]   rd_ord;
  logic [WW-1:0]   b_w;
  logic [IW-1:0]   b_a;
  logic            probe_ok, buddy_match;
  logic            ul_act;
  logic [OW-1:0]   ul_ord;
  logic [IW-1:0]   ul_addr;
  logic [OW-1:0]   o0;
  logic [WW-1:0]   n_w;
  logic            region_nz;

  assign region_wr = cfg_valid_i && (cfg_index_i == REG_REGION_PAGES);
  assign total_wr  = cfg_valid_i && (cfg_index_i == REG_TOTAL_PAGES);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= CFG_DATA_W'(1024);
      total_q  <= CFG_DATA_W'(1024);
    end else begin
      if (region_wr) region_q <= cfg_data_i;
      if (total_wr)  total_q  <= cfg_data_i;
    end
  end

  // order of the initial block
  always_comb begin
    n_w = (WW'(region_q) < WW'(PAGE_SLOTS)) ? WW'(region_q) : WW'(PAGE_SLOTS);
    region_nz = (region_q != '0);
    o0 = '0;
    for (int k = 1; k <= TOP_ORDER; k++) begin
      if ((WW'(1) << k) <= n_w) o0 = OW'(k);
    end
  end

  // request decode and status flags
  assign ro        = round_order(request_pages_i);
  assign start_bad = (ro > RO_W'(TOP_ORDER)) ||
                     ((cmd_field_i == CMD_FREE) &&
                      ((WW'(page_index_i) + (WW'(1) << ro)) > WW'(PAGE_SLOTS)));
  assign head_c      = head_q[c_q];
  assign rd_free     = fm_rd_q[FW-1];
  assign rd_ord      = fm_rd_q[OW-1:0];
  assign b_w         = WW'(fa_q) ^ (WW'(1) << fo_q);
  assign b_a         = b_w[IW-1:0];
  assign probe_ok    = (fo_q < OW'(TOP_ORDER)) && (b_w < WW'(total_q)) &&
                       (b_w < WW'(PAGE_SLOTS));
  assign buddy_match = rd_free && (rd_ord == fo_q);

  assign flags_o.region_wr   = region_wr;
  assign flags_o.clear_last  = (clr_cnt_q == IW'(PAGE_SLOTS - 1));
  assign flags_o.start_bad   = start_bad;
  assign flags_o.start_free  = (cmd_field_i == CMD_FREE);
  assign flags_o.found       = (head_c != NO_LINK);
  assign flags_o.scan_end    = (c_q == OW'(TOP_ORDER));
  assign flags_o.split_more  = (c_q > o_q);
  assign flags_o.rd_free     = rd_free;
  assign flags_o.probe_ok    = probe_ok;
  assign flags_o.buddy_match = buddy_match;
  assign flags_o.mode_alloc  = mode_alloc_q;
  assign flags_o.out_room    = !out_valid_q || !out_stall_i;

  // unlink of a free block from its order list
  always_comb begin
    ul_act  = 1'b0;
    ul_ord  = c_q;
    ul_addr = p_q;
    unique case (cmd_i.op)
      OP_TAKE: begin
        ul_act  = 1'b1;
        ul_ord  = c_q;
        ul_addr = p_q;
      end
      OP_PUNLINK: begin
        ul_act  = rd_free;
        ul_ord  = rd_ord;
        ul_addr = pa_q;
      end
      OP_JOIN: begin
        ul_act  = buddy_match;
        ul_ord  = fo_q;
        ul_addr = b_a;
      end
      default: ul_act = 1'b0;
    endcase
  end

  // memory port selection
  always_comb begin
    fm_we = 1'b0; fm_wa = pa_q; fm_wd = '0;
    nx_we = 1'b0; nx_wa = pa_q; nx_wd = NO_LINK;
    pv_we = 1'b0; pv_wa = pa_q; pv_wd = NO_LINK;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        fm_we = 1'b1;
        fm_wa = clr_cnt_q;
        fm_wd = '0;
      end
      OP_INIT: begin
        fm_we = region_nz; fm_wa = '0; fm_wd = {1'b1, o0};
        nx_we = region_nz; nx_wa = '0; nx_wd = NO_LINK;
        pv_we = region_nz; pv_wa = '0; pv_wd = NO_LINK;
      end
      OP_TAKE, OP_PUNLINK, OP_JOIN: begin
        fm_we = ul_act;
        fm_wa = ul_addr;
        fm_wd = {1'b0, ul_ord};
        nx_we = ul_act && (pv_rd_q != NO_LINK);
        nx_wa = pv_rd_q[IW-1:0];
        nx_wd = nx_rd_q;
        pv_we = ul_act && (nx_rd_q != NO_LINK);
        pv_wa = nx_rd_q[IW-1:0];
        pv_wd = pv_rd_q;
      end
      OP_PLINK: begin
        fm_we = 1'b1; fm_wa = pa_q; fm_wd = {1'b1, po_q};
        nx_we = 1'b1; nx_wa = pa_q; nx_wd = head_q[po_q];
        pv_we = 1'b1; pv_wa = pa_q; pv_wd = NO_LINK;
      end
      OP_PFIX: begin
        pv_we = (h_q != NO_LINK);
        pv_wa = h_q[IW-1:0];
        pv_wd = LW'(pa_q);
      end
      default: fm_we = 1'b0;
    endcase
  end

  // read addresses
  always_comb begin
    unique case (cmd_i.op)
      OP_START: fm_ra = IW'(WW'(page_index_i));
      OP_PROBE: fm_ra = b_a;
      default:  fm_ra = pa_q;
    endcase
    unique case (cmd_i.op)
      OP_SCAN:  ln_ra = head_c[IW-1:0];
      OP_PROBE: ln_ra = b_a;
      default:  ln_ra = pa_q;
    endcase
  end

  // page state memory
  always_ff @(posedge clk_i) begin
    if (fm_we) fm_mem[fm_wa] <= fm_wd;
    fm_rd_q <= fm_mem[fm_ra];
  end

  // next link memory
  always_ff @(posedge clk_i) begin
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    nx_rd_q <= nx_mem[ln_ra];
  end

  // previous link memory
  always_ff @(posedge clk_i) begin
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    pv_rd_q <= pv_mem[ln_ra];
  end

  // list heads and free page total
  always_comb begin
    for (int k = 0; k < HN; k++) begin
      head_d[k] = head_q[k];
    end
    sum_d = sum_q;
    if (region_wr) begin
      for (int k = 0; k < HN; k++) begin
        head_d[k] = NO_LINK;
      end
      sum_d = '0;
    end else begin
      unique case (cmd_i.op)
        OP_INIT: begin
          if (region_nz) begin
            head_d[o0] = '0;
            sum_d      = SW'(1) << o0;
          end
        end
        OP_TAKE, OP_PUNLINK, OP_JOIN: begin
          if (ul_act) begin
            if (pv_rd_q == NO_LINK) head_d[ul_ord] = nx_rd_q;
            sum_d = sum_q - (SW'(1) << ul_ord);
          end
        end
        OP_PLINK: begin
          head_d[po_q] = LW'(pa_q);
          sum_d        = sum_q + (SW'(1) << po_q);
        end
        default: sum_d = sum_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HN; k++) begin
        head_q[k] <= NO_LINK;
      end
      sum_q <= '0;
    end else begin
      for (int k = 0; k < HN; k++) begin
        head_q[k] <= head_d[k];
      end
      sum_q <= sum_d;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (region_wr) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.op == OP_CLEAR) begin
      clr_cnt_q <= clr_cnt_q + IW'(1);
    end
  end

  // working registers of the current transaction
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_START: begin
        mode_alloc_q <= (cmd_field_i == CMD_ALLOC);
        o_q          <= OW'(ro);
        c_q          <= OW'(ro);
        fa_q         <= IW'(WW'(page_index_i));
        fo_q         <= OW'(ro);
        stat_q       <= start_bad ? STAT_TOO_BIG : STAT_OK;
        blk_q        <= '0;
      end
      OP_SCAN: begin
        if (head_c != NO_LINK) begin
          p_q   <= head_c[IW-1:0];
          blk_q <= head_c[IW-1:0];
        end else if (c_q == OW'(TOP_ORDER)) begin
          stat_q <= STAT_NO_BLOCK;
        end else begin
          c_q <= c_q + OW'(1);
        end
      end
      OP_SPLIT: begin
        if (c_q > o_q) begin
          c_q  <= c_q - OW'(1);
          po_q <= c_q - OW'(1);
          pa_q <= IW'(WW'(p_q) + (WW'(1) << (c_q - OW'(1))));
        end
      end
      OP_FCHECK: begin
        if (rd_free) stat_q <= STAT_ALREADY_FREE;
      end
      OP_PROBE: begin
        pa_q <= fa_q;
        po_q <= fo_q;
      end
      OP_JOIN: begin
        if (buddy_match) begin
          fa_q <= fa_q & ~(IW'(1) << fo_q);
          fo_q <= fo_q + OW'(1);
        end
      end
      OP_PLINK: h_q <= head_q[po_q];
      default: h_q <= h_q;
    endcase
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_FIN) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FIN) begin
      out_stat_q <= stat_q;
      out_blk_q  <= BLK_W'(WW'(blk_q));
      out_free_q <= (64'(sum_q) > 64'(FREE_MAX)) ? FREE_W'(FREE_MAX) : FREE_W'(64'(sum_q));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_stat_q;
  assign block_index_o = out_blk_q;
  assign avail_pages_o = out_free_q;

endmodule

>>> src/buddy_page_allocator.sv
// buddy page allocator: one alloc or free transaction at a time, one result each
// alloc: scan the order lists upward from the rounded order, take the head block, then
//   split it down, linking each upper half; free: check the page, merge with free buddies,
//   then insert the merged block; the result goes into the result register
// only one transaction is in flight; reset or a region_pages write runs a clearing pass
//   over all PAGE_SLOTS page states during which no transaction is accepted
module buddy_page_allocator #(
  parameter int unsigned TOP_ORDER  = bpa_pkg::DEF_TOP_ORDER,
  parameter int unsigned PAGE_SLOTS = bpa_pkg::DEF_PAGE_SLOTS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bpa_pkg::CMD_W-1:0]       cmd_i,
  input  logic [bpa_pkg::REQ_W-1:0]       request_pages_i,
  input  logic [bpa_pkg::IDX_W-1:0]       page_index_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bpa_pkg::STAT_W-1:0]      status_o,
  output logic [bpa_pkg::BLK_W-1:0]       block_index_o,
  output logic [bpa_pkg::FREE_W-1:0]      avail_pages_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bpa_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bpa_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_flags_t dp_flags;

  // controller
  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .flags_i    (dp_flags),
    .cmd_o      (ctrl_cmd)
  );

  // datapath
  bpa_datapath #(
    .TOP_ORDER  (TOP_ORDER),
    .PAGE_SLOTS (PAGE_SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .flags_o         (dp_flags),
    .cmd_field_i     (cmd_i),
    .request_pages_i (request_pages_i),
    .page_index_i    (page_index_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .block_index_o   (block_index_o),
    .avail_pages_o   (avail_pages_o)
  );

  assign in_stall_o  = !ctrl_cmd.idle;
  assign cfg_ready_o = 1'b1;

  // an accepted transaction blocks the input until it completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

  // a block index is reported only for a successful alloc
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> (block_index_o == '0))
    else $error("block index set on a failed transaction");

  // a region size write starts the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_REGION_PAGES) |=> in_stall_o)
    else $error("input open right after a region size write");

endmodule
